// ===== design/register_pool_allocator_defines.svh =====
// Assertion macros for the register pool allocator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef REGISTER_POOL_ALLOCATOR_DEFINES_SVH
`define REGISTER_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpa_pkg.sv =====
// Shared types and constants of the register pool allocator.
// Used by rpa_ctrl, rpa_datapath and register_pool_allocator; no dependencies.
package rpa_pkg;

  localparam int POOL_SLOTS_DEF  = 9;
  localparam int ARG_REGS_DEF    = 6;
  localparam int SAVED_REGS_DEF  = 5;

  // Operation codes
  localparam logic [2:0] OP_INIT        = 3'd0;
  localparam logic [2:0] OP_ALLOC_TEMP  = 3'd1;
  localparam logic [2:0] OP_ALLOC_PARAM = 3'd2;
  localparam logic [2:0] OP_FREE        = 3'd3;
  localparam logic [2:0] OP_POP         = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_PARAM    = 3'd0;
  localparam logic [2:0] KIND_TEMP     = 3'd1;
  localparam logic [2:0] KIND_SLOT     = 3'd2;
  localparam logic [2:0] KIND_PUSH     = 3'd3;
  localparam logic [2:0] KIND_POP      = 3'd4;
  localparam logic [2:0] KIND_OUT_REGS = 3'd5;

  // Register ids
  localparam logic [3:0] ID_RAX   = 4'd0;
  localparam logic [3:0] ID_R10   = 4'd1;
  localparam logic [3:0] ID_R11   = 4'd2;
  localparam logic [3:0] ID_ARG0  = 4'd3;
  localparam logic [3:0] ID_EMPTY = 4'd15;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] reg_id;
    logic [2:0] param_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0] reg_out;
    logic [2:0] kind;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // execute the accepted transaction, load first result
    logic step;   // load the next result of a sequence
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;  // accepted op gives at least one result
    logic multi;       // accepted op gives more than one result
    logic last_step;   // next step loads the final result
  } sts_t;

endpackage

// ===== design/rpa_ctrl.sv =====
// Handshake controller of the register pool allocator.
// Depends on rpa_pkg; drives commands into rpa_datapath.
module rpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  rpa_pkg::sts_t sts_i,
  output rpa_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign out_valid_o = out_valid_q;

  assign cmd_o.exec = in_valid_i && !in_stall_o;
  assign cmd_o.step = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.exec) begin
        out_valid_q <= sts_i.has_result;
        if (sts_i.multi) begin
          state_q <= ST_EMIT;
        end
      end else if (cmd_o.step) begin
        out_valid_q <= 1'b1;
        if (sts_i.last_step) begin
          state_q <= ST_IDLE;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/rpa_datapath.sv =====
// Slot pool, callee counter, scan logic and result register.
// Depends on rpa_pkg; commanded by rpa_ctrl.
module rpa_datapath #(
  parameter int POOL_SLOTS  = rpa_pkg::POOL_SLOTS_DEF,
  parameter int ARG_REGS    = rpa_pkg::ARG_REGS_DEF,
  parameter int SAVED_REGS  = rpa_pkg::SAVED_REGS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpa_pkg::cmd_t     cmd_i,
  output rpa_pkg::sts_t     sts_o,
  input  rpa_pkg::in_item_t in_data_i,
  output rpa_pkg::out_item_t out_data_o
);

  localparam int CNT_W    = $clog2(SAVED_REGS + 1);
  localparam int LEFT_MAX = (ARG_REGS > SAVED_REGS) ? ARG_REGS : SAVED_REGS;
  localparam int LEFT_W   = $clog2(LEFT_MAX + 1);

  logic [3:0]       slot_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] used_q;
  logic [CNT_W-1:0] count_q;
  logic [LEFT_W-1:0] emit_left_q;
  logic             emit_up_q;
  rpa_pkg::out_item_t out_q;

  logic [POOL_SLOTS-1:0] empty_v, hit_t, hit_p, hit_f;
  logic [3:0]        init_slot [POOL_SLOTS];
  logic [3:0]        temp_id, param_id;
  logic              temp_found, param_found;
  logic [LEFT_W-1:0] pcc;
  logic [LEFT_W-1:0] first_n;
  logic              first_up;
  rpa_pkg::out_item_t first_out;

  // Priority scans over the pool
  always_comb begin
    logic seen_t, seen_f, seen_p;
    seen_t = 1'b0;
    seen_f = 1'b0;
    seen_p = 1'b0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      empty_v[i] = (slot_q[i] == rpa_pkg::ID_EMPTY);
    end
    for (int i = 0; i < POOL_SLOTS; i++) begin
      hit_t[i] = !seen_t && (empty_v[i] || !used_q[i]);
      seen_t   = seen_t || empty_v[i] || !used_q[i];
      hit_f[i] = !seen_f && (empty_v[i] || (slot_q[i] == in_data_i.reg_id));
      seen_f   = seen_f || empty_v[i] || (slot_q[i] == in_data_i.reg_id);
    end
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      hit_p[i] = !seen_p && !empty_v[i] && !used_q[i];
      seen_p   = seen_p || (!empty_v[i] && !used_q[i]);
    end
  end

  // Stop at a hole means no temp slot
  assign temp_found  = |(hit_t & ~empty_v);
  assign param_found = |hit_p;

  always_comb begin
    temp_id  = '0;
    param_id = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      temp_id  = temp_id | ((hit_t[i] && !empty_v[i]) ? slot_q[i] : 4'd0);
      param_id = param_id | (hit_p[i] ? slot_q[i] : 4'd0);
    end
  end

  assign pcc = (int'(in_data_i.param_count) > ARG_REGS) ? LEFT_W'(ARG_REGS)
                                                       : LEFT_W'(in_data_i.param_count);

  // Pool contents after init: scratch registers, then unused argument registers
  always_comb begin
    int a;
    a = 0;
    for (int j = 0; j < POOL_SLOTS; j++) begin
      if (j == 0) begin
        init_slot[j] = rpa_pkg::ID_RAX;
      end else if (j == 1) begin
        init_slot[j] = rpa_pkg::ID_R10;
      end else if (j == 2) begin
        init_slot[j] = rpa_pkg::ID_R11;
      end else begin
        a = int'(pcc) + j - 3;
        init_slot[j] = (a < ARG_REGS) ? 4'(int'(rpa_pkg::ID_ARG0) + a) : rpa_pkg::ID_EMPTY;
      end
    end
  end

  // First result and result count of the accepted transaction
  always_comb begin
    first_n   = '0;
    first_up  = 1'b1;
    first_out = '{reg_out: 4'd0, kind: rpa_pkg::KIND_OUT_REGS, last: 1'b1};
    unique case (in_data_i.op)
      rpa_pkg::OP_INIT: begin
        first_n           = pcc;
        first_out.reg_out = rpa_pkg::ID_ARG0;
        first_out.kind    = rpa_pkg::KIND_PARAM;
      end
      rpa_pkg::OP_ALLOC_TEMP: begin
        first_n = LEFT_W'(1);
        if (temp_found) begin
          first_out.reg_out = temp_id;
          first_out.kind    = rpa_pkg::KIND_TEMP;
        end else if (int'(count_q) < SAVED_REGS) begin
          first_out.reg_out = 4'(int'(rpa_pkg::ID_ARG0) + ARG_REGS + int'(count_q));
          first_out.kind    = rpa_pkg::KIND_PUSH;
        end
      end
      rpa_pkg::OP_ALLOC_PARAM: begin
        first_n = LEFT_W'(1);
        if (param_found) begin
          first_out.reg_out = param_id;
          first_out.kind    = rpa_pkg::KIND_SLOT;
        end
      end
      rpa_pkg::OP_POP: begin
        first_n           = LEFT_W'(count_q);
        first_up          = 1'b0;
        first_out.reg_out = 4'(int'(rpa_pkg::ID_ARG0) + ARG_REGS + int'(count_q) - 1);
        first_out.kind    = rpa_pkg::KIND_POP;
      end
      default: begin
        first_n = '0;
      end
    endcase
    first_out.last = (first_n == LEFT_W'(1));
  end

  assign sts_o.has_result = (first_n != '0);
  assign sts_o.multi      = (first_n > LEFT_W'(1));
  assign sts_o.last_step  = (emit_left_q == LEFT_W'(1));

  // Pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        slot_q[i] <= rpa_pkg::ID_EMPTY;
      end
      used_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      unique case (in_data_i.op)
        rpa_pkg::OP_INIT: begin
          for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_q[i] <= init_slot[i];
          end
          used_q <= '0;
        end
        rpa_pkg::OP_ALLOC_TEMP: begin
          if (temp_found) begin
            used_q <= used_q | (hit_t & ~empty_v);
          end else if (int'(count_q) < SAVED_REGS) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        rpa_pkg::OP_ALLOC_PARAM: begin
          for (int i = 0; i < POOL_SLOTS; i++) begin
            if (hit_p[i]) begin
              slot_q[i] <= rpa_pkg::ID_EMPTY;
            end
          end
        end
        rpa_pkg::OP_FREE: begin
          used_q <= used_q & ~(hit_f & ~empty_v);
        end
        rpa_pkg::OP_POP: begin
          count_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_left_q <= '0;
      emit_up_q   <= 1'b1;
    end else if (cmd_i.exec) begin
      emit_left_q <= sts_o.has_result ? first_n - LEFT_W'(1) : '0;
      emit_up_q   <= first_up;
    end else if (cmd_i.step) begin
      emit_left_q <= emit_left_q - LEFT_W'(1);
    end
  end

  // Result register; each step moves the id by one, up for init and down for pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= first_out;
    end else if (cmd_i.step) begin
      out_q.reg_out <= emit_up_q ? out_q.reg_out + 4'd1 : out_q.reg_out - 4'd1;
      out_q.last    <= sts_o.last_step;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/register_pool_allocator.sv =====
// Top level of the register pool allocator: controller plus datapath.
// Depends on rpa_pkg, rpa_ctrl, rpa_datapath and the assertion macro header.
//
//   channel  direction  payload              handshake
//   in       input      in_data_i  (in_item_t)  in_valid_i / in_stall_o
//   out      output     out_data_o (out_item_t) out_valid_o / out_stall_i
//
// Alloc ops give one result each; free and unknown ops give none. Init and
// pop give one result per register, from none up to the argument or callee
// register count; one result register hands out one per cycle unless stalled.
// The first result is valid the cycle after its transaction is accepted.
// Reset clears the pool to empty slots and the callee count at once.
// A stalled result holds in place; input is stalled while a result sequence
// is still being emitted or the result register is full and stalled.
`include "register_pool_allocator_defines.svh"

module register_pool_allocator #(
  parameter int POOL_SLOTS  = rpa_pkg::POOL_SLOTS_DEF,
  parameter int ARG_REGS    = rpa_pkg::ARG_REGS_DEF,
  parameter int SAVED_REGS  = rpa_pkg::SAVED_REGS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpa_pkg::out_item_t out_data_o
);

  rpa_pkg::cmd_t cmd;
  rpa_pkg::sts_t sts;

  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpa_datapath #(
    .POOL_SLOTS  (POOL_SLOTS),
    .ARG_REGS    (ARG_REGS),
    .SAVED_REGS  (SAVED_REGS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // Never accept a transaction while a result is stuck in the output register
  `RPA_ASSERT_NOW(a_accept_out_free, clk_i, rst_ni, in_valid_i && !in_stall_o, !(out_valid_o && out_stall_i), "input accepted over a stalled result")

  // More results follow a non-final one, so input stays blocked
  `RPA_ASSERT_NOW(a_seq_blocks_input, clk_i, rst_ni, out_valid_o && !out_data_o.last, in_stall_o, "input open inside a result sequence")

  // Free gives no result
  `RPA_ASSERT_NEXT(a_free_silent, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.op == rpa_pkg::OP_FREE), !out_valid_o, "free produced a result")

endmodule
